/* rtl/ile_pkg.sv */
package ile_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 11;
    localparam int POS_W    = 11;
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int STAT_W   = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_GET      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD_HEAD = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADD_TAIL = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_ADD_AT   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DELETE   = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  item_count;
    } res_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } mem_req_t;

endpackage

/* rtl/ile_store.sv */
module ile_store (
    input  logic                          clk,
    input  ile_pkg::mem_req_t             mem,
    output logic [ile_pkg::DATA_W-1:0]    rd_data
);

    logic [ile_pkg::DATA_W-1:0] ram [ile_pkg::CAPACITY];

    always_ff @(posedge clk)
    begin
        if (mem.wr_en)
        begin
            ram[mem.wr_addr] <= mem.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem.rd_en)
        begin
            rd_data <= ram[mem.rd_addr];
        end
    end

endmodule

/* rtl/ile_seq.sv */
module ile_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ile_pkg::req_t                 req,
    input  logic                          req_valid,
    output logic                          req_ready,
    output ile_pkg::res_t                 res,
    output logic                          res_valid,
    input  logic                          res_ready,
    output ile_pkg::mem_req_t             mem,
    input  logic [ile_pkg::DATA_W-1:0]    rd_data
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH  = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_PLACE  = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    localparam logic [ile_pkg::CNT_W-1:0] CNT_FULL = ile_pkg::CNT_W'(ile_pkg::CAPACITY);

    state_t                          state_reg, state_next;
    logic [ile_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [ile_pkg::ADDR_W-1:0]      cur_reg, cur_next;
    logic [ile_pkg::ADDR_W-1:0]      end_reg, end_next;
    logic [ile_pkg::ADDR_W-1:0]      pend_addr_reg, pend_addr_next;
    logic                            pend_reg, pend_next;
    logic                            ins_reg, ins_next;
    logic                            use_rd_reg, use_rd_next;
    logic [ile_pkg::DATA_W-1:0]      val_reg, val_next;
    logic [ile_pkg::DATA_W-1:0]      rv_reg, rv_next;
    logic [ile_pkg::STAT_W-1:0]      st_reg, st_next;

    logic                            accept;
    logic [ile_pkg::CNT_W-1:0]       ins_pos;
    logic [ile_pkg::CNT_W-1:0]       pos_inc;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign pos_inc   = req.position + ile_pkg::CNT_W'(1);

    always_comb
    begin
        case (req.func)
            ile_pkg::FUNC_ADD_HEAD: ins_pos = '0;
            ile_pkg::FUNC_ADD_TAIL: ins_pos = count_reg;
            default:                ins_pos = req.position;
        endcase
    end

    assign res.read_value = use_rd_reg ? rd_data : rv_reg;
    assign res.status     = st_reg;
    assign res.item_count = count_reg;
    assign res_valid      = (state_reg == S_FINISH);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        end_next       = end_reg;
        pend_addr_next = pend_addr_reg;
        pend_next      = pend_reg;
        ins_next       = ins_reg;
        use_rd_next    = use_rd_reg;
        val_next       = val_reg;
        rv_next        = rv_reg;
        st_next        = st_reg;
        mem            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rv_next     = '0;
                    st_next     = ile_pkg::ST_DONE;
                    use_rd_next = 1'b0;
                    val_next    = req.value;
                    pend_next   = 1'b0;
                    unique case (req.func) inside
                        ile_pkg::FUNC_GET:
                        begin
                            if (req.position < count_reg)
                            begin
                                mem.rd_en   = 1'b1;
                                mem.rd_addr = req.position[ile_pkg::ADDR_W-1:0];
                                use_rd_next = 1'b1;
                                state_next  = S_FETCH;
                            end
                            else
                            begin
                                rv_next    = '1;
                                st_next    = ile_pkg::ST_RANGE;
                                state_next = S_FINISH;
                            end
                        end
                        ile_pkg::FUNC_ADD_HEAD, ile_pkg::FUNC_ADD_TAIL, ile_pkg::FUNC_ADD_AT:
                        begin
                            if (req.func == ile_pkg::FUNC_ADD_AT && req.position > count_reg)
                            begin
                                st_next    = ile_pkg::ST_RANGE;
                                state_next = S_FINISH;
                            end
                            else if (count_reg == CNT_FULL)
                            begin
                                st_next    = ile_pkg::ST_FULL;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                count_next = count_reg + ile_pkg::CNT_W'(1);
                                ins_next   = 1'b1;
                                end_next   = ins_pos[ile_pkg::ADDR_W-1:0];
                                cur_next   = ile_pkg::ADDR_W'(count_reg - ile_pkg::CNT_W'(1));
                                state_next = (ins_pos == count_reg) ? S_PLACE : S_SHIFT;
                            end
                        end
                        ile_pkg::FUNC_DELETE:
                        begin
                            if (req.position >= count_reg)
                            begin
                                st_next    = ile_pkg::ST_RANGE;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                count_next = count_reg - ile_pkg::CNT_W'(1);
                                ins_next   = 1'b0;
                                cur_next   = pos_inc[ile_pkg::ADDR_W-1:0];
                                end_next   = ile_pkg::ADDR_W'(count_reg - ile_pkg::CNT_W'(1));
                                state_next = (pos_inc == count_reg) ? S_FINISH : S_SHIFT;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                state_next = S_FINISH;
            end
            S_SHIFT:
            begin
                // read one entry, write back the one read last cycle
                mem.rd_en      = 1'b1;
                mem.rd_addr    = cur_reg;
                mem.wr_en      = pend_reg;
                mem.wr_addr    = pend_addr_reg;
                mem.wr_data    = rd_data;
                pend_next      = 1'b1;
                pend_addr_next = ins_reg ? cur_reg + ile_pkg::ADDR_W'(1)
                                         : cur_reg - ile_pkg::ADDR_W'(1);
                if (cur_reg == end_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cur_next = ins_reg ? cur_reg - ile_pkg::ADDR_W'(1)
                                       : cur_reg + ile_pkg::ADDR_W'(1);
                end
            end
            S_DRAIN:
            begin
                mem.wr_en   = 1'b1;
                mem.wr_addr = pend_addr_reg;
                mem.wr_data = rd_data;
                state_next  = ins_reg ? S_PLACE : S_FINISH;
            end
            S_PLACE:
            begin
                mem.wr_en   = 1'b1;
                mem.wr_addr = end_reg;
                mem.wr_data = val_reg;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        end_reg       <= end_next;
        pend_addr_reg <= pend_addr_next;
        ins_reg       <= ins_next;
        use_rd_reg    <= use_rd_next;
        val_reg       <= val_next;
        rv_reg        <= rv_next;
        st_reg        <= st_next;
    end

endmodule

/* rtl/indexed_list_engine.sv */
// Ordered list of up to 1024 signed 32-bit values held in one single-port-write,
// one-read synchronous RAM.
// Request channel (s_*): one transaction carries an operation, a list index
// and a value: get, insert at head, insert at tail, insert before an index,
// delete at an index. Result channel (m_*): exactly one transaction per
// request with the value read, a status (done, index out of range, list full)
// and the item count after the request.
// Requests are handled one at a time. A rejected request or an unused code
// goes straight to the result; a get reads the RAM first; an insert shifts the
// entries from the index on up by one, then writes the value; a delete shifts
// the entries above the index down by one. The slowest request is an insert at
// the head of a list of 1023 entries. The shift walk does one RAM read and one
// write-back per cycle through the single memory.
// The result sits in an output register, so the engine may finish the
// request and leave it there while the receiver stalls; the next request is
// taken once the result has moved into that register.
// Reset clears the item count and the control state; the RAM is not cleared,
// only entries below the count are ever read.
module indexed_list_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // func[2:0], position[13:3], value[45:14], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_value[31:0], status[33:32], item_count[44:34], pad
);

    ile_pkg::req_t               req;
    ile_pkg::res_t               res;
    ile_pkg::mem_req_t           mem;
    logic [ile_pkg::DATA_W-1:0]  rd_data;
    logic                        res_valid;
    logic                        res_ready;

    logic                        m_tvalid_reg;
    logic [47:0]                 m_tdata_reg;

    // unpack request transaction
    assign req.func     = s_tdata[2:0];
    assign req.position = s_tdata[13:3];
    assign req.value    = s_tdata[45:14];

    // output register is free when empty or being taken this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    ile_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .mem       (mem),
        .rd_data   (rd_data)
    );

    ile_store u_store (
        .clk     (clk),
        .mem     (mem),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_tdata_reg <= {3'b000, res.item_count, res.status, res.read_value};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
